>>> rtl/yrc_pkg.sv
package yrc_pkg;

    // Working width of the signed per-channel sums (covers -2^19 .. 2^19-1)
    localparam int ACC_W = 20;

    localparam logic signed [ACC_W-1:0] Y_OFS     = 20'sd16;
    localparam logic signed [ACC_W-1:0] C_OFS     = 20'sd128;
    localparam logic signed [ACC_W-1:0] ROUND     = 20'sd128;
    localparam logic signed [ACC_W-1:0] K_LUMA    = 20'sd298;
    localparam logic signed [ACC_W-1:0] K_V_RED   = 20'sd409;
    localparam logic signed [ACC_W-1:0] K_U_GREEN = 20'sd100;
    localparam logic signed [ACC_W-1:0] K_U_BLUE  = 20'sd516;

    localparam logic [31:0] ALPHA_MASK = 32'hff00_0000;
    localparam logic [31:0] HALF_MASK  = 32'h007f_7f7f;

    // Scanline mode register codes; the fourth code behaves as off
    localparam logic [1:0] SCAN_OFF   = 2'd0;
    localparam logic [1:0] SCAN_HALF  = 2'd1;
    localparam logic [1:0] SCAN_BLACK = 2'd2;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } item_t;

    typedef struct packed {
        logic [31:0] pixel_first;
        logic [31:0] pixel_second;
        logic [31:0] below_first;
        logic [31:0] below_second;
        logic        below_valid;
    } result_t;

    // Chroma terms shared by both pixels of a pair
    typedef struct packed {
        logic signed [ACC_W-1:0] red_term;
        logic signed [ACC_W-1:0] green_term;
        logic signed [ACC_W-1:0] blue_term;
    } chroma_t;

endpackage

>>> rtl/yrc_chroma.sv
module yrc_chroma
(
    input  logic [7:0]      chroma_blue,
    input  logic [7:0]      chroma_red,
    output yrc_pkg::chroma_t terms
);

    logic signed [yrc_pkg::ACC_W-1:0] u_ofs;
    logic signed [yrc_pkg::ACC_W-1:0] v_ofs;
    logic signed [yrc_pkg::ACC_W-1:0] c_red;

    assign u_ofs = $signed({12'd0, chroma_blue}) - yrc_pkg::C_OFS;
    assign v_ofs = $signed({12'd0, chroma_red}) - yrc_pkg::C_OFS;
    assign c_red = yrc_pkg::K_V_RED * v_ofs;

    assign terms.red_term   = c_red;
    // floor halving of the red product feeds the green channel
    assign terms.green_term = -(yrc_pkg::K_U_GREEN * u_ofs) - (c_red >>> 1);
    assign terms.blue_term  = yrc_pkg::K_U_BLUE * u_ofs;

endmodule

>>> rtl/yrc_pixel_conv.sv
module yrc_pixel_conv
(
    input  logic [7:0]       luma,
    input  yrc_pkg::chroma_t terms,
    output logic [31:0]      pixel
);

    logic signed [yrc_pkg::ACC_W-1:0] luma_term;
    logic signed [yrc_pkg::ACC_W-1:0] sum_r;
    logic signed [yrc_pkg::ACC_W-1:0] sum_g;
    logic signed [yrc_pkg::ACC_W-1:0] sum_b;

    function automatic logic [7:0] clip8(input logic signed [yrc_pkg::ACC_W-1:0] s);
        logic [7:0] res;
        if (s[yrc_pkg::ACC_W-1])
            res = 8'd0;
        else if (|s[yrc_pkg::ACC_W-2:16])
            res = 8'd255;
        else
            res = s[15:8];
        return res;
    endfunction

    assign luma_term = yrc_pkg::K_LUMA * ($signed({12'd0, luma}) - yrc_pkg::Y_OFS);
    assign sum_r     = luma_term + terms.red_term + yrc_pkg::ROUND;
    assign sum_g     = luma_term + terms.green_term + yrc_pkg::ROUND;
    assign sum_b     = luma_term + terms.blue_term + yrc_pkg::ROUND;

    assign pixel = {8'hff, clip8(sum_b), clip8(sum_g), clip8(sum_r)};

endmodule

>>> rtl/yrc_scanline.sv
module yrc_scanline
(
    input  logic [1:0]  mode,
    input  logic [31:0] pixel_first,
    input  logic [31:0] pixel_second,
    output logic [31:0] below_first,
    output logic [31:0] below_second,
    output logic        below_valid
);

    always_comb
    begin
        unique case (mode)
            yrc_pkg::SCAN_HALF:
            begin
                below_first  = ((pixel_first >> 1) & yrc_pkg::HALF_MASK) | yrc_pkg::ALPHA_MASK;
                below_second = ((pixel_second >> 1) & yrc_pkg::HALF_MASK) | yrc_pkg::ALPHA_MASK;
                below_valid  = 1'b1;
            end
            yrc_pkg::SCAN_BLACK:
            begin
                below_first  = yrc_pkg::ALPHA_MASK;
                below_second = yrc_pkg::ALPHA_MASK;
                below_valid  = 1'b1;
            end
            default:
            begin
                // off, and the unused fourth code: drop the row below
                below_first  = 32'd0;
                below_second = 32'd0;
                below_valid  = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/yuv_to_rgba_scanline_converter_unit.sv
// YUV420 pixel-pair to RGBA converter with an optional scanline row. Pulse start with
// one luma pair and its shared chroma pair on item; busy never rises, so a new pair can
// be transferred on every clock. Each transfer yields exactly one registered result:
// done is then high for a single cycle and result holds the two RGBA pixels
// (R in 7:0, G in 15:8, B in 23:16, alpha 255 in 31:24) plus the scanline row below.
// The receiver cannot stall, so capture result whenever done is high. The rate is one
// pair per clock, set by the input register / conversion / result register pipeline.
// Write the scan mode register through cfg_we/cfg_wdata only while no transfer is in
// flight: 0 off (below_valid low, below pixels zero), 1 half brightness, 2 opaque black.
module yuv_to_rgba_scanline_converter_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  yrc_pkg::item_t   item,
    output logic             done,
    output yrc_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_wdata
);

    logic             mode_reg;
    logic [1:0]       scan_mode_reg;
    logic             valid_reg;
    yrc_pkg::item_t   item_reg;
    yrc_pkg::result_t result_reg;
    logic             done_reg;

    yrc_pkg::chroma_t terms;
    yrc_pkg::result_t result_next;

    // Pipeline never stalls: accept a pair on every cycle
    assign busy = 1'b0;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_mode_reg <= yrc_pkg::SCAN_OFF;
        else if (cfg_we)
            scan_mode_reg <= cfg_wdata;
    end

    // Control: advance the valid flag one stage per clock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            mode_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
            mode_reg  <= scan_mode_reg != yrc_pkg::SCAN_OFF;
        end
    end

    // Payload registers: hold the input pair, then the converted result
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
        if (valid_reg)
            result_reg <= result_next;
    end

    yrc_chroma u_chroma
    (
        .chroma_blue (item_reg.chroma_blue),
        .chroma_red  (item_reg.chroma_red),
        .terms       (terms)
    );

    yrc_pixel_conv u_conv_first
    (
        .luma  (item_reg.luma_first),
        .terms (terms),
        .pixel (result_next.pixel_first)
    );

    yrc_pixel_conv u_conv_second
    (
        .luma  (item_reg.luma_second),
        .terms (terms),
        .pixel (result_next.pixel_second)
    );

    yrc_scanline u_scanline
    (
        .mode         (scan_mode_reg),
        .pixel_first  (result_next.pixel_first),
        .pixel_second (result_next.pixel_second),
        .below_first  (result_next.below_first),
        .below_second (result_next.below_second),
        .below_valid  (result_next.below_valid)
    );

    assign done   = done_reg;
    assign result = result_reg;

    // A registered pair always produces a strobe on the next cycle
    a_valid_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> done)
        else $error("registered pair produced no result");

    // Every result traces back to a prior transfer on start
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without a prior transfer");

    // Both converted pixels are opaque
    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.pixel_first[31:24] == 8'hff) && (result.pixel_second[31:24] == 8'hff))
        else $error("converted pixel alpha not opaque");

    // Row below is zero when absent, and opaque with the mode flag set when present
    a_below_absent: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.below_valid |-> (result.below_first == 32'd0)
                                        && (result.below_second == 32'd0))
        else $error("absent scanline row not zero");

    a_below_present: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.below_valid |-> (result.below_first[31:24] == 8'hff)
                                       && (result.below_second[31:24] == 8'hff)
                                       && $past(mode_reg))
        else $error("scanline row malformed or flagged while mode off");

endmodule
